[sv/assert_macros.svh]
// Assertion helper macros shared by checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

[sv/slet_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted log event table package
// Shared widths, status codes and state encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package slet_pkg;
  localparam int TABLE_DEPTH = 1024;
  localparam int ID_BITS     = 48;
  localparam int SIZE_BITS   = 24;
  localparam int OFF_BITS    = 48;
  localparam int SUM_BITS    = 34;
  localparam int CNT_BITS    = $clog2(TABLE_DEPTH) + 1;
  localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
  localparam int TAG_BITS    = ID_BITS + 1;
  localparam int ENTRY_BITS  = TAG_BITS + SIZE_BITS + OFF_BITS;

  typedef logic [2:0] status_t;
  localparam status_t ST_APPEND  = 3'd0;
  localparam status_t ST_REWRITE = 3'd1;
  localparam status_t ST_ERASE   = 3'd2;
  localparam status_t ST_SKIP    = 3'd3;
  localparam status_t ST_MISSING = 3'd4;
  localparam status_t ST_ORDER   = 3'd5;
  localparam status_t ST_FULL    = 3'd6;

  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic [SIZE_BITS-1:0] size;
    logic [OFF_BITS-1:0]  offs;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LAST_RD, S_LAST_CHK, S_SRCH_RD, S_SRCH_CHK, S_HIT_RD, S_HIT_CHK,
    S_FIN, S_CMP_RD, S_CMP_CHK, S_OUT
  } state_t;
endpackage

[sv/slet_ram.sv]
// ----------------------------------------------------------------------------
// Sorted log event table entry memory
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module slet_ram import slet_pkg::*; (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  entry_t               wdata,
  output entry_t               rdata
);
  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[sv/sorted_log_event_table_core.sv]
// ----------------------------------------------------------------------------
// Sorted log event table core
// Sorted table of log event ids with binary-search rewrite and compaction.
// ----------------------------------------------------------------------------
// One event transfer gives one result transfer. A rewrite or erase runs a binary
// search of at most log2(depth)+1 steps, and the search issues one read per step
// on the single entry memory port. A compaction pass reads every held entry
// once; input stalls meanwhile. The memory needs no clearing pass: only entries
// below the table length are ever used.
`timescale 1ns / 1ps
module sorted_log_event_table_core import slet_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ID_BITS-1:0]   in_event_id,
  input  logic                 in_is_rewrite,
  input  logic                 in_is_empty,
  input  logic [SIZE_BITS-1:0] in_payload_size,
  input  logic [OFF_BITS-1:0]  in_event_offset,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic [SUM_BITS-1:0]  out_total_payload_size,
  output logic [CNT_BITS-1:0]  out_entry_count,
  output logic [CNT_BITS-1:0]  out_erased_count,
  output logic [ID_BITS-1:0]   out_last_appended_id,
  output logic                 out_compacted,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CNT_BITS-1:0]  cfg_compact_min_events
);
  state_t state_r, state_nxt;

  // Captured event.
  logic [TAG_BITS-1:0]  tag_r;
  logic                 rw_r, emp_r;
  logic [SIZE_BITS-1:0] size_r;
  logic [OFF_BITS-1:0]  offs_r;

  // Architectural state.
  logic [CNT_BITS-1:0] len_r, len_nxt, app_r, app_nxt, era_r, era_nxt, cmin_r;
  logic [SUM_BITS-1:0] sum_r, sum_nxt;
  logic [ID_BITS-1:0]  last_r, last_nxt;

  // Search and compaction pointers.
  logic [CNT_BITS-1:0] lo_r, lo_nxt, hi_r, hi_nxt, wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_BITS-1:0] mid;
  status_t             st_r, st_nxt;
  logic                cmp_r, cmp_nxt;

  logic                 we;
  logic [ADDR_BITS-1:0] addr;
  entry_t               wdata, rdata;

  slet_ram u_ram (.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_status             = st_r;
  assign out_total_payload_size = sum_r;
  assign out_entry_count        = app_r;
  assign out_erased_count       = era_r;
  assign out_last_appended_id   = last_r;
  assign out_compacted          = cmp_r;

  logic chk_compact;
  assign chk_compact = (app_nxt > cmin_r) &&
                       ({era_nxt, 2'b00} > ({1'b0, app_nxt, 1'b0} + {2'b00, app_nxt}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r <= '0; app_r <= '0; era_r <= '0; sum_r <= '0; last_r <= '0;
      cmin_r <= CNT_BITS'(10);
      st_r <= ST_APPEND; cmp_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r <= len_nxt; app_r <= app_nxt; era_r <= era_nxt;
      sum_r <= sum_nxt; last_r <= last_nxt;
      st_r <= st_nxt; cmp_r <= cmp_nxt;
      if (cfg_valid && cfg_ready) begin
        cmin_r <= cfg_compact_min_events;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt; hi_r <= hi_nxt; wp_r <= wp_nxt; rp_r <= rp_nxt;
    if (in_valid && in_ready) begin
      tag_r  <= {in_event_id, 1'b0};
      rw_r   <= in_is_rewrite;
      emp_r  <= in_is_empty;
      size_r <= in_payload_size;
      offs_r <= in_event_offset;
    end
  end

  always_comb begin
    state_nxt = state_r;
    len_nxt = len_r; app_nxt = app_r; era_nxt = era_r;
    sum_nxt = sum_r; last_nxt = last_r;
    lo_nxt = lo_r; hi_nxt = hi_r; wp_nxt = wp_r; rp_nxt = rp_r;
    st_nxt = st_r; cmp_nxt = cmp_r;
    we = 1'b0; addr = '0; wdata = rdata;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmp_nxt = 1'b0;
          state_nxt = S_LAST_RD;
        end
      end
      S_LAST_RD: begin
        addr = ADDR_BITS'(len_r - 1'b1);
        state_nxt = S_LAST_CHK;
      end
      S_LAST_CHK: begin
        // rdata holds the last entry when the table is not empty.
        if (rw_r && len_r != '0 && rdata.tag >= tag_r) begin
          lo_nxt = '0; hi_nxt = len_r;
          state_nxt = S_SRCH_RD;
        end else if (emp_r) begin
          st_nxt = ST_SKIP; state_nxt = S_FIN;
        end else if (len_r != '0 && rdata.tag >= tag_r) begin
          st_nxt = ST_ORDER; state_nxt = S_OUT;
        end else if (len_r == CNT_BITS'(TABLE_DEPTH)) begin
          st_nxt = ST_FULL; state_nxt = S_OUT;
        end else begin
          we = 1'b1;
          addr = ADDR_BITS'(len_r);
          wdata = '{tag: tag_r, size: size_r, offs: offs_r};
          len_nxt = len_r + 1'b1;
          app_nxt = app_r + 1'b1;
          sum_nxt = sum_r + SUM_BITS'(size_r);
          last_nxt = tag_r[TAG_BITS-1:1];
          st_nxt = ST_APPEND; state_nxt = S_FIN;
        end
      end
      S_SRCH_RD: begin
        if (lo_r < hi_r) begin
          addr = ADDR_BITS'(mid);
          state_nxt = S_SRCH_CHK;
        end else begin
          state_nxt = S_HIT_RD;
        end
      end
      S_SRCH_CHK: begin
        if (rdata.tag < tag_r) lo_nxt = mid + 1'b1;
        else hi_nxt = mid;
        state_nxt = S_SRCH_RD;
      end
      S_HIT_RD: begin
        addr = ADDR_BITS'(lo_r);
        state_nxt = (lo_r >= len_r) ? S_OUT : S_HIT_CHK;
        if (lo_r >= len_r) st_nxt = ST_MISSING;
      end
      S_HIT_CHK: begin
        addr = ADDR_BITS'(lo_r);
        if (rdata.tag != tag_r) begin
          st_nxt = ST_MISSING; state_nxt = S_OUT;
        end else begin
          we = 1'b1;
          if (emp_r) begin
            wdata = '{tag: tag_r | TAG_BITS'(1), size: '0, offs: '0};
            sum_nxt = sum_r - SUM_BITS'(rdata.size);
            era_nxt = era_r + 1'b1;
            st_nxt = ST_ERASE;
          end else begin
            wdata = '{tag: tag_r, size: size_r, offs: offs_r};
            sum_nxt = sum_r - SUM_BITS'(rdata.size) + SUM_BITS'(size_r);
            st_nxt = ST_REWRITE;
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        app_nxt = app_r; era_nxt = era_r;
        if (chk_compact) begin
          cmp_nxt = 1'b1; wp_nxt = '0; rp_nxt = '0;
          state_nxt = S_CMP_RD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_CMP_RD: begin
        if (rp_r < len_r) begin
          addr = ADDR_BITS'(rp_r);
          state_nxt = S_CMP_CHK;
        end else begin
          len_nxt = wp_r; app_nxt = wp_r; era_nxt = '0;
          state_nxt = S_OUT;
        end
      end
      S_CMP_CHK: begin
        // Live entries move down; write pointer never passes read pointer.
        if (!rdata.tag[0]) begin
          we = 1'b1; addr = ADDR_BITS'(wp_r); wdata = rdata;
          wp_nxt = wp_r + 1'b1;
        end
        rp_nxt = rp_r + 1'b1;
        state_nxt = S_CMP_RD;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

[sv/slet_checker.sv]
// ----------------------------------------------------------------------------
// Sorted log event table checker
// Port-level checks on the core, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module slet_checker import slet_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [2:0]          out_status,
  input logic [CNT_BITS-1:0] out_entry_count,
  input logic [CNT_BITS-1:0] out_erased_count,
  input logic                out_compacted
);
  `CHK_IMPLY(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  `CHK_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status))
  `CHK_IMPLY(a_cmp_clears, clk, rst_n, out_valid && out_compacted, out_erased_count == '0)
  `CHK_IMPLY(a_err_no_cmp, clk, rst_n, out_valid && out_status >= ST_MISSING, !out_compacted)
  `CHK_IMPLY(a_era_bound, clk, rst_n, out_valid, out_erased_count <= out_entry_count)
endmodule

bind sorted_log_event_table_core slet_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_entry_count(out_entry_count), .out_erased_count(out_erased_count),
  .out_compacted(out_compacted)
);

[dv/tb_sorted_log_event_table_core.sv]
// ----------------------------------------------------------------------------
// Sorted log event table core testbench
// Drives log events through the core with random idling on both channels,
// predicts every result with a behavioral copy of the table, and compares
// each result field by field. Covers append, rewrite, erase, skip, missing
// rewrite, out-of-order and full table, plus compaction at several
// thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_sorted_log_event_table_core;
  import slet_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ID_BITS-1:0]   in_event_id = '0;
  logic                 in_is_rewrite = 1'b0;
  logic                 in_is_empty = 1'b0;
  logic [SIZE_BITS-1:0] in_payload_size = '0;
  logic [OFF_BITS-1:0]  in_event_offset = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           out_status;
  logic [SUM_BITS-1:0]  out_total_payload_size;
  logic [CNT_BITS-1:0]  out_entry_count;
  logic [CNT_BITS-1:0]  out_erased_count;
  logic [ID_BITS-1:0]   out_last_appended_id;
  logic                 out_compacted;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CNT_BITS-1:0]  cfg_compact_min_events = '0;

  sorted_log_event_table_core uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // One expected result transfer.
  typedef struct {
    status_t             status;
    logic [SUM_BITS-1:0] total;
    logic [CNT_BITS-1:0] appended;
    logic [CNT_BITS-1:0] erased;
    logic [ID_BITS-1:0]  last_id;
    logic                compacted;
  } event_result_t;

  // Behavioral copy of the event table plus the queue of predicted results.
  class event_table_model;
    logic [TAG_BITS-1:0]  tags [TABLE_DEPTH];
    logic [SIZE_BITS-1:0] sizes [TABLE_DEPTH];
    int                   length;
    int                   appended;
    int                   erased;
    logic [SUM_BITS-1:0]  total;
    logic [ID_BITS-1:0]   last_id;
    int                   min_events;
    event_result_t        pending_results [$];
    int                   mismatches;
    int                   status_seen [8];
    int                   compactions;

    function void reset_state();
      length = 0;
      appended = 0;
      erased = 0;
      total = '0;
      last_id = '0;
      min_events = 10;
      mismatches = 0;
      compactions = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Drops erased entries while keeping the ascending order.
    function void squeeze();
      int w;
      w = 0;
      for (int r = 0; r < length; r++) begin
        if (!tags[r][0]) begin
          tags[w] = tags[r];
          sizes[w] = sizes[r];
          w++;
        end
      end
      length = w;
      appended = w;
      erased = 0;
    endfunction

    // Applies one accepted event and queues the result it should give.
    function void note_event(logic [ID_BITS-1:0] id, logic rw, logic empty,
                             logic [SIZE_BITS-1:0] size);
      logic [TAG_BITS-1:0] tag;
      status_t             st;
      int                  pos;
      event_result_t       res;
      tag = {id, 1'b0};
      res.compacted = 1'b0;
      if (rw && length > 0 && tags[length-1] >= tag) begin
        pos = -1;
        for (int i = 0; i < length; i++) if (tags[i] == tag) pos = i;
        if (pos < 0) begin
          st = ST_MISSING;
        end else begin
          total = total - sizes[pos];
          if (empty) begin
            tags[pos] = tag + 1'b1;
            sizes[pos] = '0;
            erased++;
            st = ST_ERASE;
          end else begin
            total = total + size;
            sizes[pos] = size;
            st = ST_REWRITE;
          end
        end
      end else if (empty) begin
        st = ST_SKIP;
      end else if (length > 0 && tags[length-1] >= tag) begin
        st = ST_ORDER;
      end else if (length >= TABLE_DEPTH) begin
        st = ST_FULL;
      end else begin
        tags[length] = tag;
        sizes[length] = size;
        length++;
        appended++;
        total = total + size;
        last_id = id;
        st = ST_APPEND;
      end
      // Only successful steps may trigger a compaction pass.
      if (st <= ST_SKIP && appended > min_events && erased * 4 > appended * 3) begin
        squeeze();
        res.compacted = 1'b1;
        compactions++;
      end
      status_seen[st]++;
      res.status = st;
      res.total = total;
      res.appended = appended[CNT_BITS-1:0];
      res.erased = erased[CNT_BITS-1:0];
      res.last_id = last_id;
      pending_results = {pending_results, res};
    endfunction

    function void report(string field, logic [63:0] exp_v, logic [63:0] act_v);
      mismatches++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, field, exp_v, act_v);
    endfunction

    // Compares one result transfer with the oldest prediction.
    function void check_result(event_result_t act);
      event_result_t exp_r;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with no event outstanding, status %0d",
                 $realtime, act.status);
        return;
      end
      exp_r = pending_results.pop_front();
      if (act.status !== exp_r.status)
        report("status", 64'(exp_r.status), 64'(act.status));
      if (act.total !== exp_r.total)
        report("total_payload_size", 64'(exp_r.total), 64'(act.total));
      if (act.appended !== exp_r.appended)
        report("entry_count", 64'(exp_r.appended), 64'(act.appended));
      if (act.erased !== exp_r.erased)
        report("erased_count", 64'(exp_r.erased), 64'(act.erased));
      if (act.last_id !== exp_r.last_id)
        report("last_appended_id", 64'(exp_r.last_id), 64'(act.last_id));
      if (act.compacted !== exp_r.compacted)
        report("compacted", 64'(exp_r.compacted), 64'(act.compacted));
    endfunction
  endclass

  event_table_model    table_model = new();
  bit                  steady_feed;   // when set, events go back to back
  int                  erase_percent;
  logic [ID_BITS-1:0]  fill_base;

  // Mostly short gaps, now and then a long one.
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Holds one event until its transfer, then records it in the model.
  task automatic send_event(logic [ID_BITS-1:0] id, logic rw, logic empty,
                            logic [SIZE_BITS-1:0] size, logic [OFF_BITS-1:0] offs);
    int gap;
    in_valid <= 1'b1;
    in_event_id <= id;
    in_is_rewrite <= rw;
    in_is_empty <= empty;
    in_payload_size <= size;
    in_event_offset <= offs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    table_model.note_event(id, rw, empty, size);
    gap = steady_feed ? 0 : gap_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drops valid, then lets every outstanding result drain before a register write.
  task automatic drain();
    in_valid <= 1'b0;
    while (table_model.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_min_events(int value);
    drain();
    cfg_valid <= 1'b1;
    cfg_compact_min_events <= value[CNT_BITS-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    table_model.min_events = value;
  endtask

  function automatic logic [OFF_BITS-1:0] random_offset();
    return OFF_BITS'({$urandom(), $urandom()});
  endfunction

  // Erases every live entry, walking the model's table from the top.
  task automatic erase_live_entries();
    for (int i = table_model.length - 1; i >= 0; i--) begin
      if (i < table_model.length && !table_model.tags[i][0])
        send_event(table_model.tags[i][TAG_BITS-1:1], 1'b1, 1'b1,
                   SIZE_BITS'($urandom()), random_offset());
    end
  endtask

  // One random event. Most are well-formed appends and rewrites of ids that
  // are held; the rest are misses, skips and out-of-order noise.
  task automatic send_random_event();
    int                  r;
    int                  idx;
    logic [ID_BITS-1:0]  base;
    logic [ID_BITS-1:0]  id;
    base = table_model.length > 0 ? table_model.tags[table_model.length-1][TAG_BITS-1:1] : '0;
    r = $urandom_range(0, 99);
    if (r < 40 || table_model.length == 0) begin
      id = base + ID_BITS'(($urandom_range(0, 19) == 0) ?
                           {$urandom(), $urandom()} >> $urandom_range(8, 40) :
                           $urandom_range(1, 50));
      send_event(id, 1'($urandom_range(0, 1)), 1'b0, SIZE_BITS'($urandom()),
                 random_offset());
    end else if (r < 75) begin
      idx = $urandom_range(0, table_model.length - 1);
      send_event(table_model.tags[idx][TAG_BITS-1:1], 1'b1,
                 $urandom_range(0, 99) < erase_percent, SIZE_BITS'($urandom()),
                 random_offset());
    end else if (r < 83) begin
      // Rewrite of an id that may be absent or already erased.
      id = ID_BITS'(($urandom_range(0, 3) == 0) ? {$urandom(), $urandom()} :
                    base - $urandom_range(0, 60));
      send_event(id, 1'b1, 1'($urandom_range(0, 1)), SIZE_BITS'($urandom()),
                 random_offset());
    end else if (r < 92) begin
      send_event(ID_BITS'({$urandom(), $urandom()}), 1'b0, 1'b1, SIZE_BITS'($urandom()),
                 random_offset());
    end else begin
      id = ID_BITS'(($urandom_range(0, 9) == 0) ? {$urandom(), $urandom()} :
                    base - $urandom_range(0, 5));
      send_event(id, 1'b0, 1'b0, SIZE_BITS'($urandom()), random_offset());
    end
  endtask

  // The result side accepts in bursts separated by random stalls.
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      r_gap: begin
        int stall;
        stall = gap_cycles();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      event_result_t act;
      act.status = out_status;
      act.total = out_total_payload_size;
      act.appended = out_entry_count;
      act.erased = out_erased_count;
      act.last_id = out_last_appended_id;
      act.compacted = out_compacted;
      table_model.check_result(act);
    end
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    table_model.reset_state();
    steady_feed = 1'b0;
    erase_percent = 40;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed events at the default threshold.
    send_event('0, 1'b0, 1'b0, '0, '0);                    // first append, id zero
    send_event('0, 1'b0, 1'b0, 24'd5, '0);                 // same id again: out of order
    send_event(48'd5, 1'b1, 1'b1, 24'd9, '1);              // empty beyond the last: skip
    send_event('0, 1'b1, 1'b0, '1, '1);                    // rewrite with the largest size
    send_event(48'd7, 1'b1, 1'b0, 24'd3, 48'd77);          // rewrite flag beyond the last: append
    send_event(48'd3, 1'b1, 1'b0, 24'd1, 48'd1);           // rewrite of an absent id
    send_event('0, 1'b1, 1'b1, 24'd4, '0);                 // erase
    send_event('0, 1'b1, 1'b0, 24'd4, '0);                 // rewrite of an erased id
    send_event('0, 1'b1, 1'b1, 24'd4, '0);                 // erase of an erased id
    send_event(48'd9, 1'b0, 1'b0, '1, '1);
    send_event(48'h8000_0000_0000, 1'b0, 1'b0, 24'h80_0000, 48'h8000_0000_0000);
    send_event('1, 1'b0, 1'b0, 24'h55_5555, 48'hAAAA_AAAA_AAAA);   // largest id
    send_event('1, 1'b1, 1'b0, 24'hAA_AAAA, 48'h5555_5555_5555);   // rewrite at the top
    send_event(48'd12, 1'b0, 1'b0, 24'd2, 48'd2);          // below the top: out of order

    // With no threshold, erasing everything compacts the table down to nothing.
    write_min_events(0);
    erase_live_entries();

    // Random phases over several thresholds and erase rates.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_min_events(10);
        1: write_min_events(0);
        2: write_min_events($urandom_range(1, TABLE_DEPTH));
        default: write_min_events(3);
      endcase
      erase_percent = (phase == 2) ? 15 : 70;
      repeat (200) send_random_event();
    end

    // Largest threshold: fill the table from its last id, overflow it, then
    // work inside it.
    write_min_events(TABLE_DEPTH);
    fill_base = table_model.length > 0 ?
                table_model.tags[table_model.length-1][TAG_BITS-1:1] : '0;
    steady_feed = 1'b1;
    for (int i = 1; i <= TABLE_DEPTH; i++)
      send_event(fill_base + ID_BITS'(i) * 3, 1'b0, 1'b0, '1, random_offset());
    steady_feed = 1'b0;
    send_event(fill_base + ID_BITS'(TABLE_DEPTH + 1) * 3, 1'b0, 1'b0, 24'd1, '0);   // full
    repeat (40) send_random_event();

    in_valid <= 1'b0;
    while (table_model.pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Events by status (append..full): %0d %0d %0d %0d %0d %0d %0d",
             table_model.status_seen[ST_APPEND], table_model.status_seen[ST_REWRITE],
             table_model.status_seen[ST_ERASE], table_model.status_seen[ST_SKIP],
             table_model.status_seen[ST_MISSING], table_model.status_seen[ST_ORDER],
             table_model.status_seen[ST_FULL]);
    $display("Compaction passes: %0d, field mismatches: %0d",
             table_model.compactions, table_model.mismatches);
    if (table_model.mismatches == 0 && table_model.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
